FILE: rtl/core/p2c_pkg.sv
// Package with the shared types and constants of the planar to chunky converter.
`default_nettype none
package p2c_pkg;

  localparam int FRAME_LINES  = 200;
  localparam int LINE_COLUMNS = 40;

  localparam int OFS_W    = 18;
  localparam int STRIDE_W = 11;
  localparam int LINE_W   = 8;
  localparam int COL_W    = 6;
  localparam int PIX_W    = 5;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 4;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd320;
  localparam logic [OFS_W-1:0]    OFS_STEP     = 18'd16;
  localparam logic [LINE_W-1:0]   LAST_LINE    = LINE_W'(FRAME_LINES - 1);
  localparam logic [COL_W-1:0]    LAST_COL     = COL_W'(LINE_COLUMNS - 1);
  localparam logic [CNT_W-1:0]    WORD_LAST    = 4'd15;
  localparam logic [CNT_W-1:0]    BYTE_LAST    = 4'd7;

  typedef enum logic [0:0] {
    CFG_PLANE_MODE  = 1'b0,
    CFG_LINE_STRIDE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] plane_0;
    logic [WORD_W-1:0] plane_1;
    logic [WORD_W-1:0] plane_2;
    logic [WORD_W-1:0] plane_3;
    logic [BYTE_W-1:0] plane_4;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [OFS_W-1:0] dest_offset;
    logic             run_last;
  } out_item_t;

  // One item as handed from the position logic to the serializer.
  typedef struct packed {
    logic [WORD_W-1:0] plane_0;
    logic [WORD_W-1:0] plane_1;
    logic [WORD_W-1:0] plane_2;
    logic [WORD_W-1:0] plane_3;
    logic [BYTE_W-1:0] plane_4;
    logic              mode;
    logic [OFS_W-1:0]  base;
  } job_t;

  typedef struct packed {
    logic             busy;
    logic             step;
    logic [CNT_W-1:0] cnt;
    logic [OFS_W-1:0] ofs;
  } ser_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/p2c_pos.sv
// Configuration registers and destination position counters.
`default_nettype none
module p2c_pos (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire p2c_pkg::cfg_reg_t  cfg_index,
  input  wire logic [10:0]        cfg_data,
  input  wire logic               in_fire,
  input  wire p2c_pkg::in_item_t  in_data,
  output p2c_pkg::job_t           job
);
  import p2c_pkg::*;

  logic                plane_mode;
  logic [STRIDE_W-1:0] line_stride;
  logic [OFS_W-1:0]    linear_offset;
  logic [LINE_W-1:0]   line_count;
  logic [COL_W-1:0]    column_count;

  logic [OFS_W-1:0]           lin;
  logic [LINE_W-1:0]          line;
  logic [COL_W-1:0]           col;
  logic [LINE_W+STRIDE_W-1:0] line_mul;
  logic [OFS_W-1:0]           grid_base;
  logic [LINE_W-1:0]          line_next;
  logic [COL_W-1:0]           col_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    // A frame start clears every counter before the item uses them.
    lin  = in_data.frame_start ? '0 : linear_offset;
    line = in_data.frame_start ? '0 : line_count;
    col  = in_data.frame_start ? '0 : column_count;

    line_mul  = {{STRIDE_W{1'b0}}, line} * {{LINE_W{1'b0}}, line_stride};
    grid_base = OFS_W'(line_mul) + OFS_W'({col, 3'b000});

    if (col == LAST_COL) begin
      col_next  = '0;
      line_next = (line == LAST_LINE) ? '0 : line + 1'b1;
    end else begin
      col_next  = col + 1'b1;
      line_next = line;
    end

    job.plane_0 = in_data.plane_0;
    job.plane_1 = in_data.plane_1;
    job.plane_2 = in_data.plane_2;
    job.plane_3 = in_data.plane_3;
    job.plane_4 = in_data.plane_4;
    job.mode    = plane_mode;
    job.base    = plane_mode ? grid_base : lin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_mode    <= 1'b0;
      line_stride   <= STRIDE_RESET;
      linear_offset <= '0;
      line_count    <= '0;
      column_count  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PLANE_MODE:  plane_mode  <= cfg_data[0];
          CFG_LINE_STRIDE: line_stride <= cfg_data;
        endcase
      end
      if (in_fire) begin
        linear_offset <= plane_mode ? lin : lin + OFS_STEP;
        column_count  <= plane_mode ? col_next : col;
        line_count    <= plane_mode ? line_next : line;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/p2c_serial.sv
// Plane shift registers that emit one chunky pixel per cycle into the output register while it is not stalled.
`default_nettype none
module p2c_serial (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire p2c_pkg::job_t       job,
  output logic                     accept_ok,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output p2c_pkg::out_item_t       out_data,
  output p2c_pkg::ser_stat_t       stat
);
  import p2c_pkg::*;

  logic              busy;
  logic              mode;
  logic [CNT_W-1:0]  cnt;
  logic [OFS_W-1:0]  ofs;
  logic [WORD_W-1:0] sh0;
  logic [WORD_W-1:0] sh1;
  logic [WORD_W-1:0] sh2;
  logic [WORD_W-1:0] sh3;
  logic [BYTE_W-1:0] sh4;

  logic out_load;
  logic step;
  logic done;

  assign out_load  = !out_valid || !out_stall;
  assign step      = busy && out_load;
  assign done      = step && (cnt == '0);
  // The next item may enter in the same cycle the last pixel moves out.
  assign accept_ok = !busy || done;

  assign stat.busy = busy;
  assign stat.step = step;
  assign stat.cnt  = cnt;
  assign stat.ofs  = ofs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.pixel_index <= {mode & sh4[BYTE_W-1], sh3[WORD_W-1], sh2[WORD_W-1],
                               sh1[WORD_W-1], sh0[WORD_W-1]};
      out_data.dest_offset <= ofs;
      out_data.run_last    <= (cnt == '0);
    end
    if (load) begin
      mode <= job.mode;
      ofs  <= job.base;
      sh4  <= job.plane_4;
      if (job.mode) begin
        // Byte planes sit in the low half; move them up so bit 7 leaves first.
        sh0 <= {job.plane_0[BYTE_W-1:0], {BYTE_W{1'b0}}};
        sh1 <= {job.plane_1[BYTE_W-1:0], {BYTE_W{1'b0}}};
        sh2 <= {job.plane_2[BYTE_W-1:0], {BYTE_W{1'b0}}};
        sh3 <= {job.plane_3[BYTE_W-1:0], {BYTE_W{1'b0}}};
        cnt <= BYTE_LAST;
      end else begin
        sh0 <= job.plane_0;
        sh1 <= job.plane_1;
        sh2 <= job.plane_2;
        sh3 <= job.plane_3;
        cnt <= WORD_LAST;
      end
    end else if (step) begin
      sh0 <= {sh0[WORD_W-2:0], 1'b0};
      sh1 <= {sh1[WORD_W-2:0], 1'b0};
      sh2 <= {sh2[WORD_W-2:0], 1'b0};
      sh3 <= {sh3[WORD_W-2:0], 1'b0};
      sh4 <= {sh4[BYTE_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      ofs <= ofs + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/planar_to_chunky_converter.sv
// Top level of the planar to chunky converter.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | in_data: plane_0..plane_4, frame_start
//   out     | out_valid/out_stall| out_data: pixel_index, dest_offset, run_last
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (11 bits)
//
// An item gives 16 pixels in plane mode 0 and 8 pixels in mode 1, one pixel per cycle
// while the output is not stalled, from the serializer that feeds the single output register.
// An input transfer loads the shift registers, from which the first pixel moves into the output register.
// A new item is taken in the cycle its predecessor's last pixel moves out.
// Reset is synchronous and clears the counters, the mode and the stride to 320.
// Output stall freezes the serializer; input stall is held while it is busy, but not as its last pixel moves out.
`default_nettype none
module planar_to_chunky_converter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire p2c_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output p2c_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire p2c_pkg::cfg_reg_t  cfg_index,
  input  wire logic [10:0]        cfg_data
);
  import p2c_pkg::*;

  logic      in_fire;
  logic      accept_ok;
  job_t      job;
  ser_stat_t stat;

  assign in_stall = !accept_ok;
  assign in_fire  = in_valid && !in_stall;

  p2c_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .job       (job)
  );

  p2c_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .job       (job),
    .accept_ok (accept_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !stat.busy |-> !in_stall)
    else $error("input stalled while the serializer is idle");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    stat.step && (stat.cnt == '0) |=> out_valid && out_data.run_last)
    else $error("final pixel of an item not marked as last");

  a_mid_pixel: assert property (@(posedge clk) disable iff (rst)
    stat.step && (stat.cnt != '0) |=>
      out_valid && !out_data.run_last && stat.busy &&
      (stat.cnt == $past(stat.cnt) - 1'b1) &&
      (out_data.dest_offset == $past(stat.ofs)))
    else $error("serializer count or offset out of step");

endmodule
`default_nettype wire
